@@ hw/rtl/set_assoc_cache_tag_replacement_core_macros.svh @@
// Assertion macros for the cache tag and replacement core.
`ifndef SET_ASSOC_CACHE_TAG_REPLACEMENT_CORE_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_REPLACEMENT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SACT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define SACT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define SACT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SACT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/sact_pkg.sv @@
// Shared types and constants of the cache tag and replacement core.
`default_nettype none
package sact_pkg;
	localparam logic [1:0] POL_FIFO = 2'd0;
	localparam logic [1:0] POL_LRU  = 2'd1;
	localparam logic [1:0] POL_NRU  = 2'd2;
	localparam logic [1:0] REG_BLOCK = 2'd0;
	localparam logic [1:0] REG_SETS  = 2'd1;
	localparam logic [1:0] REG_WAYS  = 2'd2;
	localparam logic [1:0] REG_POL   = 2'd3;
	localparam int CFG_W = 5;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_READ  = 5'b00100,
		ST_WORK  = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;
endpackage
`default_nettype wire

@@ hw/rtl/set_assoc_cache_tag_replacement_core.sv @@
// Top level of the cache tag and replacement core.
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/ready    | address, mode
// rsp     | out       | rsp_valid/ready    | hit, memory_read, memory_write, way_used, totals
// cfg     | in        | cfg_we             | cfg_index, cfg_data
// A request passes through accept, set read, update and write back, and result.
// The result becomes valid after the READ and WORK states that follow the accepting edge and waits there for rsp_ready.
// Each set is one wide memory row holding all ways' tags, ages and NRU bits, read in IDLE
// and again in READ, and written once per request; the set fill counts sit in a second memory.
// After reset a clearing pass over all 2^MAX_SETS_LOG2 sets zeroes the fill memory and the
// whole rows, tags as well as age and NRU fields; no request is taken until it ends.
// A stalled result holds its register; the next request is taken in the cycle after it leaves.
`default_nettype none
`include "set_assoc_cache_tag_replacement_core_macros.svh"
module set_assoc_cache_tag_replacement_core #(
	parameter int MAX_SETS_LOG2 = 8,
	parameter int MAX_WAYS_LOG2 = 3,
	parameter int ADDR_BITS     = 48
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [4:0]           cfg_data,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire logic [ADDR_BITS-1:0] address,
	input  wire logic                 mode,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output logic                      hit,
	output logic                      memory_read,
	output logic                      memory_write,
	output logic [2:0]                way_used,
	output logic [31:0]               hit_total,
	output logic [31:0]               miss_total,
	output logic [31:0]               read_total,
	output logic [31:0]               write_total
);
	localparam int NW   = 1 << MAX_WAYS_LOG2;
	localparam int NS   = 1 << MAX_SETS_LOG2;
	localparam int SW   = (MAX_SETS_LOG2 > 0) ? MAX_SETS_LOG2 : 1;
	localparam int AW   = MAX_WAYS_LOG2 > 0 ? MAX_WAYS_LOG2 : 1;
	localparam int FW   = MAX_WAYS_LOG2 + 1;
	localparam int ROWW = NW * (ADDR_BITS + AW + 1);

	logic [4:0] block_q;
	logic [3:0] sets_q;
	logic [1:0] ways_q;
	logic [1:0] pol_q;

	sact_pkg::state_t st_q;
	logic [SW-1:0]        clr_q;
	logic [ADDR_BITS-1:0] tag_q;
	logic [SW-1:0]        set_q;
	logic                 mode_q;
	logic [31:0]          hc_q, mc_q, rc_q, wc_q;

	// Row memory: per way a tag, an age and an NRU bit.
	logic [ADDR_BITS-1:0] tg [NW];
	logic [AW-1:0]        ag [NW];
	logic                 nr [NW];
	logic [ROWW-1:0]      row_rd, row_wd;
	logic [FW-1:0]        fill_rd, fill_wd;
	logic                 row_we, fill_we;
	logic [SW-1:0]        waddr, raddr;

	// Set and tag split of the incoming address.
	logic [3:0]           sl;
	logic [ADDR_BITS-1:0] blk, in_tag;
	logic [SW-1:0]        in_set;

	always_comb begin
		sl     = (sets_q > 4'(MAX_SETS_LOG2)) ? 4'(MAX_SETS_LOG2) : sets_q;
		blk    = address >> block_q;
		in_set = SW'(blk & ((ADDR_BITS'(1) << sl) - ADDR_BITS'(1)));
		in_tag = blk >> sl;
	end

	// After acceptance the port may already carry the next request, so the held set is read.
	assign raddr = (st_q == sact_pkg::ST_IDLE) ? in_set : set_q;
	assign waddr = (st_q == sact_pkg::ST_CLEAR) ? clr_q : set_q;

	sact_ram #(.WIDTH(ROWW), .DEPTH(NS)) u_row (
		.clk(clk), .we(row_we), .waddr(waddr), .wdata(row_wd),
		.raddr(raddr), .rdata(row_rd)
	);
	sact_ram #(.WIDTH(FW), .DEPTH(NS)) u_fill (
		.clk(clk), .we(fill_we), .waddr(waddr), .wdata(fill_wd),
		.raddr(raddr), .rdata(fill_rd)
	);

	always_comb begin
		for (int i = 0; i < NW; i++) begin
			tg[i] = row_rd[i*(ADDR_BITS+AW+1) +: ADDR_BITS];
			ag[i] = row_rd[i*(ADDR_BITS+AW+1)+ADDR_BITS +: AW];
			nr[i] = row_rd[i*(ADDR_BITS+AW+1)+ADDR_BITS+AW];
		end
	end

	// Update logic for the set held in the row register.
	logic [2:0]    wl;
	logic [FW-1:0] ways, valid;
	logic          h, any_nru;
	logic [AW-1:0] way, va, hage;
	logic [ADDR_BITS-1:0] ntg [NW];
	logic [AW-1:0]        nag [NW];
	logic                 nnr [NW];

	always_comb begin
		wl    = (3'(ways_q) > 3'(MAX_WAYS_LOG2)) ? 3'(MAX_WAYS_LOG2) : 3'(ways_q);
		ways  = FW'(1) << wl;
		valid = (fill_rd < ways) ? fill_rd : ways;
		h     = 1'b0;
		way   = '0;
		for (int i = NW - 1; i >= 0; i--) begin
			if (FW'(i) < valid && tg[i] == tag_q) begin
				h   = 1'b1;
				way = AW'(i);
			end
		end
		for (int i = 0; i < NW; i++) begin
			ntg[i] = tg[i];
			nag[i] = ag[i];
			nnr[i] = nr[i];
		end
		va      = '0;
		hage    = ag[way];
		any_nru = 1'b0;
		fill_wd = fill_rd;
		if (h) begin
			if (pol_q == sact_pkg::POL_LRU) begin
				for (int i = 0; i < NW; i++) begin
					if (FW'(i) < valid && AW'(i) != way && ag[i] < hage) begin
						nag[i] = ag[i] + AW'(1);
					end
				end
				nag[way] = '0;
			end else if (pol_q == sact_pkg::POL_NRU) begin
				nnr[way] = 1'b0;
			end
		end else begin
			if (valid < ways) begin
				way     = AW'(valid);
				fill_wd = valid + FW'(1);
				if (pol_q == sact_pkg::POL_LRU) begin
					for (int i = 0; i < NW; i++) begin
						if (FW'(i) < valid && ag[i] != {AW{1'b1}}) begin
							nag[i] = ag[i] + AW'(1);
						end
					end
					nag[way] = '0;
				end else if (pol_q == sact_pkg::POL_NRU) begin
					nnr[way] = 1'b0;
				end else begin
					nag[way] = AW'(valid);
				end
			end else if (pol_q == sact_pkg::POL_LRU) begin
				va = ag[0];
				for (int i = 1; i < NW; i++) begin
					if (FW'(i) < ways && ag[i] > va) begin
						va  = ag[i];
						way = AW'(i);
					end
				end
				for (int i = 0; i < NW; i++) begin
					if (FW'(i) < ways && AW'(i) != way && ag[i] < va) begin
						nag[i] = ag[i] + AW'(1);
					end
				end
				nag[way] = '0;
			end else if (pol_q == sact_pkg::POL_NRU) begin
				for (int i = NW - 1; i >= 0; i--) begin
					if (FW'(i) < ways && nr[i]) begin
						any_nru = 1'b1;
						way     = AW'(i);
					end
				end
				if (!any_nru) begin
					for (int i = 0; i < NW; i++) begin
						if (FW'(i) < ways) begin
							nnr[i] = 1'b1;
						end
					end
					way = '0;
				end
				nnr[way] = 1'b0;
			end else begin
				va = ag[0];
				for (int i = 1; i < NW; i++) begin
					if (FW'(i) < ways && ag[i] < va) begin
						va  = ag[i];
						way = AW'(i);
					end
				end
				for (int i = 0; i < NW; i++) begin
					if (FW'(i) < ways && AW'(i) != way && ag[i] > va) begin
						nag[i] = ag[i] - AW'(1);
					end
				end
				nag[way] = AW'(ways - FW'(1));
			end
			ntg[way] = tag_q;
		end
		for (int i = 0; i < NW; i++) begin
			row_wd[i*(ADDR_BITS+AW+1) +: ADDR_BITS+AW+1] = {nnr[i], nag[i], ntg[i]};
		end
		if (st_q == sact_pkg::ST_CLEAR) begin
			fill_wd = '0;
			for (int i = 0; i < NW; i++) begin
				row_wd[i*(ADDR_BITS+AW+1) +: ADDR_BITS+AW+1] = '0;
			end
		end
	end

	assign row_we    = (st_q == sact_pkg::ST_CLEAR) || (st_q == sact_pkg::ST_WORK);
	assign fill_we   = row_we;
	assign req_ready = (st_q == sact_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_q <= 5'd2;
			sets_q  <= 4'd4;
			ways_q  <= 2'd0;
			pol_q   <= sact_pkg::POL_FIFO;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sact_pkg::REG_BLOCK: block_q <= cfg_data;
				sact_pkg::REG_SETS:  sets_q  <= cfg_data[3:0];
				sact_pkg::REG_WAYS:  ways_q  <= cfg_data[1:0];
				sact_pkg::REG_POL:   pol_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	function automatic logic [31:0] sat(input logic [31:0] c, input logic en);
		return (en && c != '1) ? c + 32'd1 : c;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= sact_pkg::ST_CLEAR;
			clr_q     <= '0;
			hc_q      <= '0;
			mc_q      <= '0;
			rc_q      <= '0;
			wc_q      <= '0;
			rsp_valid <= 1'b0;
		end else begin
			unique case (st_q)
				sact_pkg::ST_CLEAR: begin
					clr_q <= clr_q + SW'(1);
					if (clr_q == SW'(NS - 1)) begin
						st_q <= sact_pkg::ST_IDLE;
					end
				end
				sact_pkg::ST_IDLE: begin
					if (req_valid) begin
						st_q <= sact_pkg::ST_READ;
					end
				end
				sact_pkg::ST_READ: st_q <= sact_pkg::ST_WORK;
				sact_pkg::ST_WORK: begin
					hc_q      <= sat(hc_q, h);
					mc_q      <= sat(mc_q, !h);
					rc_q      <= sat(rc_q, !h);
					wc_q      <= sat(wc_q, mode_q);
					rsp_valid <= 1'b1;
					st_q      <= sact_pkg::ST_OUT;
				end
				sact_pkg::ST_OUT: begin
					if (rsp_ready) begin
						rsp_valid <= 1'b0;
						st_q      <= sact_pkg::ST_IDLE;
					end
				end
				default: st_q <= sact_pkg::ST_IDLE;
			endcase
		end
	end

	// The first memory read is issued while the request sits at the port; READ rereads the held set.
	always_ff @(posedge clk) begin
		if (st_q == sact_pkg::ST_IDLE) begin
			tag_q  <= in_tag;
			set_q  <= in_set;
			mode_q <= mode;
		end
		if (st_q == sact_pkg::ST_WORK) begin
			hit          <= h;
			memory_read  <= !h;
			memory_write <= mode_q;
			way_used     <= 3'(way);
		end
	end

	assign hit_total   = hc_q;
	assign miss_total  = mc_q;
	assign read_total  = rc_q;
	assign write_total = wc_q;

	`SACT_ASSERT_IMP(a_ready_idle, clk, arst_n, req_ready, !rsp_valid)
	`SACT_ASSERT_NXT(a_accept_read, clk, arst_n, req_valid && req_ready, st_q == sact_pkg::ST_READ)
	`SACT_ASSERT_NXT(a_one_count, clk, arst_n, st_q == sact_pkg::ST_WORK,
		hc_q + mc_q == $past(hc_q) + $past(mc_q) + 32'd1 || hc_q == '1 || mc_q == '1)
endmodule
`default_nettype wire

@@ hw/rtl/sact_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module sact_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
